// ===== hw/rtl/tglc_pkg.sv =====
// Types, constants and helper functions for the tilt gesture LED colour controller.
package tglc_pkg;

    localparam int unsigned AXIS_W   = 16;
    localparam int unsigned CHAN_W   = 8;
    localparam int unsigned MODE_W   = 4;
    localparam int unsigned HUE_W    = 9;
    localparam int unsigned BRIGHT_W = 8;
    localparam int unsigned TILT_W   = 20;
    localparam int unsigned FLIP_W   = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 20;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS_MAX = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TILT_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLIP_THRESHOLD = 2'd2;

    // reset values
    localparam logic [BRIGHT_W-1:0]      BRIGHTNESS_RST = 8'd100;
    localparam logic [TILT_W-1:0]        TILT_RST       = 20'd50000;
    localparam logic signed [FLIP_W-1:0] FLIP_RST       = -16'sd10000;

    // display modes
    localparam logic [MODE_W-1:0] MODE_HUE     = 4'd0;
    localparam logic [MODE_W-1:0] MODE_RED     = 4'd1;
    localparam logic [MODE_W-1:0] MODE_GREEN   = 4'd2;
    localparam logic [MODE_W-1:0] MODE_BLUE    = 4'd3;
    localparam logic [MODE_W-1:0] MODE_MAGENTA = 4'd4;
    localparam logic [MODE_W-1:0] MODE_YELLOW  = 4'd5;
    localparam logic [MODE_W-1:0] MODE_CYAN    = 4'd6;
    localparam logic [MODE_W-1:0] MODE_WHITE   = 4'd7;
    localparam logic [MODE_W-1:0] MODE_OFF     = 4'd8;
    localparam logic [MODE_W-1:0] MODE_ACCEL   = 4'd9;
    localparam logic [MODE_W-1:0] MODE_LAST    = MODE_ACCEL;

    localparam logic [HUE_W-1:0] HUE_LAST = 9'd359;

    typedef struct packed {
        logic signed [AXIS_W-1:0] accel_x;
        logic signed [AXIS_W-1:0] accel_y;
        logic signed [AXIS_W-1:0] accel_z;
        logic                     sample_ready;
    } in_item_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [MODE_W-1:0] current_mode;
    } out_item_t;

    // v * bmax / 255, truncated; exact for any product of two 8-bit values
    function automatic logic [CHAN_W-1:0] scale_chan(input logic [CHAN_W-1:0] v,
                                                     input logic [BRIGHT_W-1:0] bmax);
        logic [15:0] prod;
        logic [16:0] sum;
        prod = v * bmax;
        sum  = {1'b0, prod} + {9'd0, prod[15:8]} + 17'd1;
        return sum[15:8];
    endfunction

    // |a| / 64, clamped to 255
    function automatic logic [CHAN_W-1:0] axis_mag(input logic signed [AXIS_W-1:0] a);
        logic [AXIS_W:0] mag;
        mag = a[AXIS_W-1] ? (17'd0 - {a[AXIS_W-1], a}) : {1'b0, a};
        return (mag[AXIS_W:14] != 3'd0) ? 8'd255 : mag[13:6];
    endfunction

    // |a| / 64 truncated, the magnitude of the signed quotient
    function automatic logic [9:0] axis_div(input logic signed [AXIS_W-1:0] a);
        logic [AXIS_W:0] mag;
        mag = a[AXIS_W-1] ? (17'd0 - {a[AXIS_W-1], a}) : {1'b0, a};
        return mag[15:6];
    endfunction

endpackage

// ===== hw/rtl/tilt_gesture_led_color_controller_unit.sv =====
// Top level of the tilt gesture LED colour controller: input register, tick logic, result register.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------------
//  in      | input     | in_valid / in_stall  | in_data  (accel_x/y/z, sample_ready)
//  out     | output    | out_valid / out_stall| out_data (red, green, blue, current_mode)
//  cfg     | input     | cfg_we               | cfg_index, cfg_data
//
// One beat a cycle while out_stall stays low; a taken beat moves from the input register into the result register.
// Tick logic sits between the input register and the result register; mode, gesture,
// pending and hue state update as a beat moves into the result register.
// in_stall rises only when both registers hold beats and out_stall is high.
// rst_n clears the state to mode 0, disarmed, sample pending, hue 0 and default registers.
module tilt_gesture_led_color_controller_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  tglc_pkg::in_item_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output tglc_pkg::out_item_t                 out_data,
    input  logic                                cfg_we,
    input  logic [tglc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tglc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic                                   in_valid_reg;
    tglc_pkg::in_item_t                     in_item_reg;
    logic                                   out_valid_reg;
    tglc_pkg::out_item_t                    out_item_reg;
    tglc_pkg::out_item_t                    out_item_next;

    logic [tglc_pkg::BRIGHT_W-1:0]          brightness_reg;
    logic [tglc_pkg::TILT_W-1:0]            tilt_reg;
    logic signed [tglc_pkg::FLIP_W-1:0]     flip_reg;

    logic [tglc_pkg::MODE_W-1:0]            mode_reg, mode_next;
    logic                                   armed_reg, armed_next;
    logic                                   pending_reg, pending_next;
    logic [tglc_pkg::HUE_W-1:0]             hue_reg, hue_next;

    logic accept, advance;

    logic                                   pend;
    logic [9:0]                             xs, ys;
    logic [19:0]                            tilt_sum;
    logic [2:0]                             region;
    logic [tglc_pkg::HUE_W-1:0]             hue_base;
    logic [5:0]                             hue_rem;
    logic [9:0]                             hue_t17;
    logic [tglc_pkg::CHAN_W-1:0]            t, q;
    logic [tglc_pkg::CHAN_W-1:0]            hr, hg, hb;
    logic [tglc_pkg::CHAN_W-1:0]            mr, mg, mb;
    logic [tglc_pkg::CHAN_W-1:0]            ar, ag, ab;
    logic [tglc_pkg::CHAN_W-1:0]            sr, sg, sb;
    logic [tglc_pkg::CHAN_W-1:0]            full;

    // handshake
    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_item_reg <= in_data;
        if (advance)
            out_item_reg <= out_item_next;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg <= tglc_pkg::BRIGHTNESS_RST;
            tilt_reg       <= tglc_pkg::TILT_RST;
            flip_reg       <= tglc_pkg::FLIP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tglc_pkg::CFG_BRIGHTNESS_MAX: brightness_reg <= cfg_data[7:0];
                tglc_pkg::CFG_TILT_THRESHOLD: tilt_reg       <= cfg_data;
                tglc_pkg::CFG_FLIP_THRESHOLD: flip_reg       <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // tick state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= tglc_pkg::MODE_HUE;
            armed_reg   <= 1'b0;
            pending_reg <= 1'b1;
            hue_reg     <= '0;
        end
        else if (advance)
        begin
            mode_reg    <= mode_next;
            armed_reg   <= armed_next;
            pending_reg <= pending_next;
            hue_reg     <= hue_next;
        end
    end

    // gesture update
    always_comb
    begin
        pend     = pending_reg | in_item_reg.sample_ready;
        xs       = tglc_pkg::axis_div(in_item_reg.accel_x);
        ys       = tglc_pkg::axis_div(in_item_reg.accel_y);
        tilt_sum = xs * xs + ys * ys;
        mode_next    = mode_reg;
        armed_next   = armed_reg;
        pending_next = pend;
        if (pend)
        begin
            if (armed_reg)
            begin
                if (in_item_reg.accel_z < flip_reg)
                    mode_next = (mode_reg == tglc_pkg::MODE_LAST) ? tglc_pkg::MODE_HUE
                                                                  : mode_reg + 4'd1;
                armed_next = 1'b0;
            end
            else if (tilt_sum > tilt_reg)
                armed_next = 1'b1;
            pending_next = 1'b0;
        end
    end

    // hue wheel: split into 60-degree sectors, t = rem * 255 / 60 = rem * 17 / 4
    always_comb
    begin
        if (hue_reg < 9'd60)
            region = 3'd0;
        else if (hue_reg < 9'd120)
            region = 3'd1;
        else if (hue_reg < 9'd180)
            region = 3'd2;
        else if (hue_reg < 9'd240)
            region = 3'd3;
        else if (hue_reg < 9'd300)
            region = 3'd4;
        else
            region = 3'd5;
        case (region)
            3'd0:    hue_base = 9'd0;
            3'd1:    hue_base = 9'd60;
            3'd2:    hue_base = 9'd120;
            3'd3:    hue_base = 9'd180;
            3'd4:    hue_base = 9'd240;
            default: hue_base = 9'd300;
        endcase
        hue_rem = 6'(hue_reg - hue_base);
        hue_t17 = {4'd0, hue_rem} * 10'd17;
        t = hue_t17[9:2];
        q = 8'd255 - t;
        case (region)
            3'd0:    begin hr = 8'd255; hg = t;      hb = 8'd0;   end
            3'd1:    begin hr = q;      hg = 8'd255; hb = 8'd0;   end
            3'd2:    begin hr = 8'd0;   hg = 8'd255; hb = t;      end
            3'd3:    begin hr = 8'd0;   hg = q;      hb = 8'd255; end
            3'd4:    begin hr = t;      hg = 8'd0;   hb = 8'd255; end
            default: begin hr = 8'd255; hg = 8'd0;   hb = q;      end
        endcase
    end

    // accelerometer colour, weakest channel zeroed
    always_comb
    begin
        ar = tglc_pkg::axis_mag(in_item_reg.accel_x);
        ag = tglc_pkg::axis_mag(in_item_reg.accel_y);
        ab = tglc_pkg::axis_mag(in_item_reg.accel_z);
        if (ar < ab && ar < ag)
            ar = 8'd0;
        else if (ab < ag)
            ab = 8'd0;
        else
            ag = 8'd0;
    end

    // shared scalers serve the hue wheel and the accelerometer colour
    always_comb
    begin
        if (mode_next == tglc_pkg::MODE_HUE)
        begin
            mr = hr; mg = hg; mb = hb;
        end
        else
        begin
            mr = ar; mg = ag; mb = ab;
        end
        sr   = tglc_pkg::scale_chan(mr, brightness_reg);
        sg   = tglc_pkg::scale_chan(mg, brightness_reg);
        sb   = tglc_pkg::scale_chan(mb, brightness_reg);
        full = brightness_reg;  // 255 scaled is the brightness itself
    end

    always_comb
    begin
        out_item_next.red          = '0;
        out_item_next.green        = '0;
        out_item_next.blue         = '0;
        out_item_next.current_mode = mode_next;
        hue_next                   = hue_reg;
        unique case (mode_next)
            tglc_pkg::MODE_HUE:
            begin
                out_item_next.red   = sr;
                out_item_next.green = sg;
                out_item_next.blue  = sb;
                hue_next = (hue_reg >= tglc_pkg::HUE_LAST) ? '0 : hue_reg + 9'd1;
            end
            tglc_pkg::MODE_RED:     out_item_next.red = full;
            tglc_pkg::MODE_GREEN:   out_item_next.green = full;
            tglc_pkg::MODE_BLUE:    out_item_next.blue = full;
            tglc_pkg::MODE_MAGENTA:
            begin
                out_item_next.red  = full;
                out_item_next.blue = full;
            end
            tglc_pkg::MODE_YELLOW:
            begin
                out_item_next.red   = full;
                out_item_next.green = full;
            end
            tglc_pkg::MODE_CYAN:
            begin
                out_item_next.green = full;
                out_item_next.blue  = full;
            end
            tglc_pkg::MODE_WHITE:
            begin
                out_item_next.red   = 8'd255;
                out_item_next.green = 8'd255;
                out_item_next.blue  = 8'd255;
            end
            tglc_pkg::MODE_ACCEL:
            begin
                out_item_next.red   = sr;
                out_item_next.green = sg;
                out_item_next.blue  = sb;
            end
            default: ;  // off
        endcase
    end

endmodule

// ===== test/tb_top.sv =====
// Self-checking bench for the tilt gesture LED colour controller: directed table, then random ticks.
`timescale 1ns / 100ps

module tb_top;
    import tglc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int IDLE_LIMIT = 2000;
    localparam int REPORT_MAX = 10;
    localparam int PHASES     = 6;
    localparam int FULL_ON    = 255;

    typedef struct packed {
        in_item_t  beat;
        logic      typed;
        out_item_t colour;
    } row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid;
    logic                  in_stall;
    in_item_t              in_data;
    logic                  out_valid;
    logic                  out_stall;
    out_item_t             out_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // shadow of the block state and registers
    logic [MODE_W-1:0] mode_now;
    logic              armed;
    logic              pending;
    logic [HUE_W-1:0]  hue;
    int                bright_reg;
    int                tilt_reg;
    int                flip_reg;

    out_item_t colour_q[$];
    row_t      directed_rows[$];
    int        phase_len[PHASES] = '{150, 60, 160, 160, 160, 160};
    int        mismatch_cnt = 0;
    int        idle_cycles = 0;
    int        send_burst = 0;
    int        take_burst = 0;
    int        stall_left = 0;

    tilt_gesture_led_color_controller_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int dim(int v);
        return (v * bright_reg) / 255;
    endfunction

    function automatic int axis_level(logic signed [AXIS_W-1:0] a);
        int m;
        m = int'(a);
        if (m < 0)
            m = -m;
        m = m / 64;
        return (m > 255) ? 255 : m;
    endfunction

    // one tick: gesture update, then colour for the updated mode
    function automatic out_item_t next_colour(in_item_t b);
        int        xs;
        int        ys;
        int        r;
        int        g;
        int        bl;
        int        h;
        int        t;
        int        q;
        out_item_t c;
        if (b.sample_ready)
            pending = 1'b1;
        if (pending)
        begin
            if (armed)
            begin
                if (int'(b.accel_z) < flip_reg)
                    mode_now = (mode_now == MODE_LAST) ? MODE_HUE : mode_now + 1'b1;
                armed = 1'b0;
            end
            else
            begin
                xs = int'(b.accel_x) / 64;
                ys = int'(b.accel_y) / 64;
                if (xs * xs + ys * ys > tilt_reg)
                    armed = 1'b1;
            end
            pending = 1'b0;
        end
        r = 0;
        g = 0;
        bl = 0;
        case (mode_now)
            MODE_HUE:
            begin
                h = int'(hue);
                t = (h % 60) * 255 / 60;
                q = 255 - t;
                case (h / 60)
                    0:       {r, g, bl} = {FULL_ON, t, 32'd0};
                    1:       {r, g, bl} = {q, FULL_ON, 32'd0};
                    2:       {r, g, bl} = {32'd0, FULL_ON, t};
                    3:       {r, g, bl} = {32'd0, q, FULL_ON};
                    4:       {r, g, bl} = {t, 32'd0, FULL_ON};
                    default: {r, g, bl} = {FULL_ON, 32'd0, q};
                endcase
                {r, g, bl} = {dim(r), dim(g), dim(bl)};
                hue = (hue == HUE_LAST) ? '0 : hue + 1'b1;
            end
            MODE_RED:     r = dim(FULL_ON);
            MODE_GREEN:   g = dim(FULL_ON);
            MODE_BLUE:    bl = dim(FULL_ON);
            MODE_MAGENTA: {r, bl} = {dim(FULL_ON), dim(FULL_ON)};
            MODE_YELLOW:  {r, g} = {dim(FULL_ON), dim(FULL_ON)};
            MODE_CYAN:    {g, bl} = {dim(FULL_ON), dim(FULL_ON)};
            MODE_WHITE:   {r, g, bl} = {FULL_ON, FULL_ON, FULL_ON};
            MODE_ACCEL:
            begin
                r = axis_level(b.accel_x);
                g = axis_level(b.accel_y);
                bl = axis_level(b.accel_z);
                // weakest channel dark; red only when strictly weakest, and a blue/green tie darkens green
                if (r < bl && r < g)
                    r = 0;
                else if (bl < g)
                    bl = 0;
                else
                    g = 0;
                {r, g, bl} = {dim(r), dim(g), dim(bl)};
            end
            default: ;
        endcase
        c.red = 8'(r);
        c.green = 8'(g);
        c.blue = 8'(bl);
        c.current_mode = mode_now;
        return c;
    endfunction

    // mostly no pause, some short, a few long; occasional runs with none
    function automatic int pick_pause(inout int burst);
        int roll;
        if (burst > 0)
        begin
            burst--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3)
            burst = $urandom_range(20, 60);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    function automatic logic [AXIS_W-1:0] big_axis();
        int m;
        m = $urandom_range(8000, 32768);
        return $urandom_range(0, 1) ? 16'(-m) : 16'(m);
    endfunction

    // tilts and flips with random content, the rest noise
    function automatic in_item_t random_tick();
        in_item_t b;
        int       kind;
        b.accel_x = 16'($urandom());
        b.accel_y = 16'($urandom());
        b.accel_z = 16'($urandom());
        b.sample_ready = 1'($urandom());
        kind = $urandom_range(0, 99);
        if (kind < 35)
        begin
            b.accel_x = big_axis();
            b.accel_y = big_axis();
            b.sample_ready = ($urandom_range(0, 9) != 0);
        end
        else if (kind < 70)
        begin
            b.accel_z = 16'(-int'($urandom_range(8000, 32768)));
            b.sample_ready = ($urandom_range(0, 9) != 0);
        end
        return b;
    endfunction

    function automatic void add_row(int x, int y, int z, logic ready, logic typed,
                                    int r, int g, int b, logic [MODE_W-1:0] m);
        row_t row;
        row.beat.accel_x = 16'(x);
        row.beat.accel_y = 16'(y);
        row.beat.accel_z = 16'(z);
        row.beat.sample_ready = ready;
        row.typed = typed;
        row.colour.red = 8'(r);
        row.colour.green = 8'(g);
        row.colour.blue = 8'(b);
        row.colour.current_mode = m;
        directed_rows.push_back(row);
    endfunction

    task automatic feed(input in_item_t beat, input logic typed, input out_item_t typed_colour);
        int        gap;
        out_item_t c;
        gap = pick_pause(send_burst);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= beat;
        do
            @(posedge clk);
        while (in_stall);
        c = next_colour(beat);
        colour_q.push_back(typed ? typed_colour : c);
    endtask

    task automatic program_regs(input int bright, input int tilt, input int flip);
        logic signed [FLIP_W-1:0] f16;
        cfg_we <= 1'b1;
        cfg_index <= CFG_BRIGHTNESS_MAX;
        cfg_data <= {12'($urandom()), 8'(bright)};
        @(posedge clk);
        cfg_index <= CFG_TILT_THRESHOLD;
        cfg_data <= 20'(tilt);
        @(posedge clk);
        cfg_index <= CFG_FLIP_THRESHOLD;
        cfg_data <= {4'($urandom()), 16'(flip)};
        @(posedge clk);
        // no register behind this index
        cfg_index <= CFG_UNUSED;
        cfg_data <= 20'($urandom());
        @(posedge clk);
        cfg_we <= 1'b0;
        f16 = 16'(flip);
        bright_reg = bright & 'hFF;
        tilt_reg = tilt & 'hFFFFF;
        flip_reg = f16;
    endtask

    always @(posedge clk)
    begin : take_results
        out_item_t want;
        int        pause;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (colour_q.size() == 0)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= REPORT_MAX)
                        $display("result with none expected: rgb %0d/%0d/%0d mode %0d",
                                 out_data.red, out_data.green, out_data.blue,
                                 out_data.current_mode);
                end
                else
                begin
                    want = colour_q.pop_front();
                    if (want.red !== out_data.red || want.green !== out_data.green ||
                        want.blue !== out_data.blue ||
                        want.current_mode !== out_data.current_mode)
                    begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= REPORT_MAX)
                            $display("mismatch: want %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                                     want.red, want.green, want.blue, want.current_mode,
                                     out_data.red, out_data.green, out_data.blue,
                                     out_data.current_mode);
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                pause = pick_pause(take_burst);
                stall_left = (pause > 0) ? pause - 1 : 0;
                out_stall <= (pause > 0);
            end
        end
    end

    // cycles with no beat moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        in_valid <= 1'b0;
        in_data <= '0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        mode_now = MODE_HUE;
        armed = 1'b0;
        pending = 1'b1;
        hue = '0;
        bright_reg = BRIGHTNESS_RST;
        tilt_reg = TILT_RST;
        flip_reg = FLIP_RST;

        // reset registers: full scale 100, tilt 50000, flip -10000
        //       x       y       z       rdy typed r    g    b    mode
        add_row(0,      0,      0,      0,  1,    100, 0,   0,   MODE_HUE);
        add_row(12800,  6400,   -32768, 1,  0,    0,   0,   0,   MODE_HUE);   // sum equals threshold
        add_row(32767,  32767,  0,      1,  0,    0,   0,   0,   MODE_HUE);   // arm
        add_row(0,      0,      -32768, 0,  0,    0,   0,   0,   MODE_HUE);   // no sample
        add_row(0,      0,      -10000, 1,  0,    0,   0,   0,   MODE_HUE);   // z on threshold
        add_row(-32768, -32768, 0,      1,  0,    0,   0,   0,   MODE_HUE);
        add_row(0,      0,      -10001, 1,  1,    100, 0,   0,   MODE_RED);
        add_row(12864,  6400,   0,      1,  1,    100, 0,   0,   MODE_RED);
        add_row(0,      0,      -32768, 1,  1,    0,   100, 0,   MODE_GREEN);
        add_row(-32767, 0,      0,      1,  1,    0,   100, 0,   MODE_GREEN);
        add_row(0,      0,      -32768, 1,  1,    0,   0,   100, MODE_BLUE);
        add_row(32767,  0,      0,      1,  1,    0,   0,   100, MODE_BLUE);
        add_row(0,      0,      -32768, 1,  1,    100, 0,   100, MODE_MAGENTA);
        add_row(32767,  0,      0,      1,  1,    100, 0,   100, MODE_MAGENTA);
        add_row(0,      0,      -32768, 1,  1,    100, 100, 0,   MODE_YELLOW);
        add_row(32767,  0,      0,      1,  1,    100, 100, 0,   MODE_YELLOW);
        add_row(0,      0,      -32768, 1,  1,    0,   100, 100, MODE_CYAN);
        add_row(32767,  0,      0,      1,  1,    0,   100, 100, MODE_CYAN);
        add_row(0,      0,      -32768, 1,  1,    255, 255, 255, MODE_WHITE);
        add_row(32767,  0,      0,      1,  1,    255, 255, 255, MODE_WHITE);
        add_row(0,      0,      -32768, 1,  1,    0,   0,   0,   MODE_OFF);
        add_row(32767,  32767,  0,      1,  1,    0,   0,   0,   MODE_OFF);
        add_row(-32768, 6400,   -32768, 1,  0,    0,   0,   0,   MODE_HUE);   // clamp, green weakest
        add_row(640,    32767,  3200,   1,  0,    0,   0,   0,   MODE_HUE);   // red weakest
        add_row(32767,  12800,  -6400,  0,  0,    0,   0,   0,   MODE_HUE);   // blue weakest

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            feed(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].colour);
        in_valid <= 1'b0;

        for (int p = 0; p < PHASES; p++)
        begin
            while (colour_q.size() != 0)
                @(posedge clk);
            repeat (4) @(posedge clk);
            case (p)
                0:       program_regs(255, 0, 32767);
                1:       program_regs(0, 524288, -32768);
                2:       program_regs(BRIGHTNESS_RST, TILT_RST, FLIP_RST);
                default: program_regs($urandom_range(0, 255), $urandom_range(0, 200000),
                                      int'($urandom_range(0, 65535)) - 32768);
            endcase
            for (int i = 0; i < phase_len[p]; i++)
                feed(random_tick(), 1'b0, '0);
            in_valid <= 1'b0;
        end

        while (colour_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatch_cnt == 0 && colour_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
